// ===== design/qwt_pkg.sv =====
package qwt_pkg;

   typedef enum logic [2:0] {
      MODE_GAP     = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_QUOTED  = 3'd2,
      MODE_ESCAPE  = 3'd3,
      MODE_DISCARD = 3'd4
   } mode_type;

   localparam logic [1:0] KIND_BYTE     = 2'd0;
   localparam logic [1:0] KIND_WORD_END = 2'd1;
   localparam logic [1:0] KIND_LINE_END = 2'd2;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL      = 2'd2;

   localparam logic CSR_COMMENTS_ENABLE = 1'b0;
   localparam logic CSR_QUOTES_ENABLE   = 1'b1;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   // result queue holds two words of one item plus two in flight
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [1:0] status;
      logic [7:0] word_count;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } scan_out_type;

endpackage

// ===== design/qwt_scan.sv =====
module qwt_scan import qwt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   char_in,
   input  logic         comments_enable,
   input  logic         quotes_enable,
   output scan_out_type scan_out
);

   mode_type   mode_ff, mode_in;
   logic       quote_ff, quote_in;
   logic [1:0] err_ff, err_in;
   logic [7:0] words_ff, words_in;

   logic [7:0] words_inc;
   logic       is_sep;
   logic       is_quote;
   logic [7:0] closer;
   logic [1:0] line_status;
   logic [7:0] line_words;
   result_type r_byte;
   result_type r_word_end;
   result_type r_line_end;
   logic       emit_byte;
   logic       emit_word_end;
   logic       emit_line_end;
   logic [7:0] byte_val;

   always_comb begin
      words_inc = (words_ff == 8'hFF) ? words_ff : words_ff + 8'd1;
      is_sep    = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB) ||
                  (char_in == CHAR_LF) || (char_in == CHAR_CR);
      is_quote  = (char_in == CHAR_DQUOTE) || (char_in == CHAR_SQUOTE);
      closer    = quote_ff ? CHAR_SQUOTE : CHAR_DQUOTE;
   end

   always_comb begin
      mode_in       = mode_ff;
      quote_in      = quote_ff;
      err_in        = err_ff;
      words_in      = words_ff;
      emit_byte     = 1'b0;
      emit_word_end = 1'b0;
      emit_line_end = 1'b0;
      byte_val      = char_in;
      line_status   = err_ff;
      line_words    = words_ff;
      if (char_in == CHAR_NUL) begin
         emit_line_end = 1'b1;
         if (mode_ff == MODE_WORD) begin
            emit_word_end = 1'b1;
            line_words    = words_inc;
         end
         if (mode_ff == MODE_QUOTED || mode_ff == MODE_ESCAPE) begin
            line_status = ERR_UNTERMINATED;
         end
         if (line_status != ERR_NONE) begin
            line_words = 8'd0;
         end
         mode_in  = MODE_GAP;
         quote_in = 1'b0;
         err_in   = ERR_NONE;
         words_in = 8'd0;
      end else begin
         unique case (mode_ff)
            MODE_GAP: begin
               if (is_sep) begin
                  mode_in = MODE_GAP;
               end else if (comments_enable && char_in == CHAR_HASH) begin
                  mode_in = MODE_DISCARD;
               end else if (quotes_enable && is_quote) begin
                  mode_in  = MODE_QUOTED;
                  quote_in = (char_in == CHAR_SQUOTE);
               end else begin
                  mode_in   = MODE_WORD;
                  emit_byte = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_sep) begin
                  emit_word_end = 1'b1;
                  words_in      = words_inc;
                  mode_in       = MODE_GAP;
               end else begin
                  emit_byte = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (char_in == closer) begin
                  if (err_ff != ERR_NONE) begin
                     mode_in = MODE_DISCARD;
                  end else begin
                     emit_word_end = 1'b1;
                     words_in      = words_inc;
                     mode_in       = MODE_GAP;
                  end
               end else if (char_in == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else if (err_ff == ERR_NONE) begin
                  emit_byte = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_QUOTED;
               if (err_ff == ERR_NONE) begin
                  if (char_in == CHAR_BACKSLASH || is_quote) begin
                     emit_byte = 1'b1;
                  end else if (char_in == CHAR_LOWER_N) begin
                     emit_byte = 1'b1;
                     byte_val  = CHAR_LF;
                  end else begin
                     err_in = ERR_ILLEGAL;
                  end
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_comb begin
      r_byte            = '0;
      r_byte.kind       = KIND_BYTE;
      r_byte.char_out   = byte_val;
      r_byte.last       = 1'b1;
      r_word_end        = '0;
      r_word_end.kind   = KIND_WORD_END;
      r_word_end.last   = !emit_line_end;
      r_line_end        = '0;
      r_line_end.kind   = KIND_LINE_END;
      r_line_end.status = line_status;
      r_line_end.word_count = line_words;
      r_line_end.last   = 1'b1;

      scan_out        = '0;
      if (emit_line_end && emit_word_end) begin
         scan_out.num    = 2'd2;
         scan_out.first  = r_word_end;
         scan_out.second = r_line_end;
      end else if (emit_line_end) begin
         scan_out.num   = 2'd1;
         scan_out.first = r_line_end;
      end else if (emit_word_end) begin
         scan_out.num   = 2'd1;
         scan_out.first = r_word_end;
      end else if (emit_byte) begin
         scan_out.num   = 2'd1;
         scan_out.first = r_byte;
      end
      if (!accept) begin
         scan_out.num = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_GAP;
         quote_ff <= 1'b0;
         err_ff   <= ERR_NONE;
         words_ff <= 8'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         err_ff   <= err_in;
         words_ff <= words_in;
      end
   end

endmodule

// ===== design/qwt_fifo.sv =====
module qwt_fifo import qwt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  scan_out_type push,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_word
);

   result_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic [FIFO_PTR_W-1:0] wr_ptr_next;
   logic                  pop;

   always_comb begin
      pop         = out_valid && out_ready;
      wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + FIFO_PTR_W'(push.num);
      rd_ptr_in   = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in    = count_ff + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
   end

   assign room      = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/quoted_word_tokenizer.sv =====
// Splits a line, one byte per word on the req channel, into shell style
// words; a zero byte ends the line. Each input byte is decoded in the cycle it
// is accepted and its zero, one or two results go into a four-deep result
// queue, so one byte is taken every cycle as long as the queue has room for
// two results; a line end that closes a plain word gives two results. rsp_kind
// marks word byte, end of word or end of line; at end of line rsp_status and
// rsp_word_count report the line, and the consumer drops the words of a line
// whose status is not ok.
module quoted_word_tokenizer import qwt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_word_count,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_data
);

   logic         comments_enable_ff;
   logic         quotes_enable_ff;
   logic         accept;
   scan_out_type scan_out;
   result_type   out_word;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         comments_enable_ff <= 1'b0;
         quotes_enable_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COMMENTS_ENABLE: comments_enable_ff <= csr_data;
            CSR_QUOTES_ENABLE:   quotes_enable_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   qwt_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .char_in         (req_char_in),
      .comments_enable (comments_enable_ff),
      .quotes_enable   (quotes_enable_ff),
      .scan_out        (scan_out)
   );

   qwt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (scan_out),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_kind       = out_word.kind;
   assign rsp_char_out   = out_word.char_out;
   assign rsp_status     = out_word.status;
   assign rsp_word_count = out_word.word_count;
   assign rsp_last       = out_word.last;

endmodule

// ===== test/qwt_checker.sv =====
`timescale 1ns / 1ps

module qwt_checker import qwt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_char_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_char_out,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_word_count,
   input  logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_data,
   output int         errors,
   output int         pending
);

   result_type expected_tokens[$];

   logic       comments_on;
   logic       quotes_on;
   mode_type   scan_state;
   logic       quote_single;
   logic [1:0] line_error;
   logic [7:0] word_total;
   int         tokens_this_byte;
   int         token_index;

   initial begin
      errors = 0;
      pending = 0;
      token_index = 0;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("ERROR: token %0d %s: got %0h expected %0h", token_index, what, got, want);
      errors++;
   endtask

   task automatic add_token(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [1:0] status, input logic [7:0] count);
      result_type r;
      r.kind = kind;
      r.char_out = ch;
      r.status = status;
      r.word_count = count;
      r.last = 1'b0;
      expected_tokens.push_back(r);
      tokens_this_byte++;
   endtask

   task automatic close_word();
      if (word_total != 8'hFF)
         word_total++;
      add_token(KIND_WORD_END, 8'h00, ERR_NONE, 8'h00);
   endtask

   task automatic clear_line();
      scan_state = MODE_GAP;
      quote_single = 1'b0;
      line_error = ERR_NONE;
      word_total = 8'h00;
   endtask

   function automatic logic is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   task automatic tokenize_byte(input logic [7:0] c);
      logic [1:0] line_status;
      logic [7:0] closer;
      result_type tail;
      tokens_this_byte = 0;
      if (c == CHAR_NUL) begin
         if (scan_state == MODE_WORD)
            close_word();
         if (scan_state == MODE_QUOTED || scan_state == MODE_ESCAPE)
            line_status = ERR_UNTERMINATED;
         else
            line_status = line_error;
         add_token(KIND_LINE_END, 8'h00, line_status,
                   line_status == ERR_NONE ? word_total : 8'h00);
         clear_line();
      end else begin
         case (scan_state)
            MODE_GAP: begin
               if (is_blank(c)) begin
               end else if (comments_on && c == CHAR_HASH) begin
                  scan_state = MODE_DISCARD;
               end else if (quotes_on && (c == CHAR_DQUOTE || c == CHAR_SQUOTE)) begin
                  scan_state = MODE_QUOTED;
                  quote_single = (c == CHAR_SQUOTE);
               end else begin
                  scan_state = MODE_WORD;
                  add_token(KIND_BYTE, c, ERR_NONE, 8'h00);
               end
            end
            MODE_WORD: begin
               if (is_blank(c)) begin
                  close_word();
                  scan_state = MODE_GAP;
               end else begin
                  add_token(KIND_BYTE, c, ERR_NONE, 8'h00);
               end
            end
            MODE_QUOTED: begin
               closer = quote_single ? CHAR_SQUOTE : CHAR_DQUOTE;
               if (c == closer) begin
                  if (line_error != ERR_NONE) begin
                     scan_state = MODE_DISCARD;
                  end else begin
                     close_word();
                     scan_state = MODE_GAP;
                  end
               end else if (c == CHAR_BACKSLASH) begin
                  scan_state = MODE_ESCAPE;
               end else if (line_error == ERR_NONE) begin
                  add_token(KIND_BYTE, c, ERR_NONE, 8'h00);
               end
            end
            MODE_ESCAPE: begin
               scan_state = MODE_QUOTED;
               if (line_error == ERR_NONE) begin
                  if (c == CHAR_BACKSLASH || c == CHAR_DQUOTE || c == CHAR_SQUOTE)
                     add_token(KIND_BYTE, c, ERR_NONE, 8'h00);
                  else if (c == CHAR_LOWER_N)
                     add_token(KIND_BYTE, CHAR_LF, ERR_NONE, 8'h00);
                  else
                     line_error = ERR_ILLEGAL;
               end
            end
            default: begin
            end
         endcase
      end
      if (tokens_this_byte > 0) begin
         tail = expected_tokens.pop_back();
         tail.last = 1'b1;
         expected_tokens.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         comments_on = 1'b0;
         quotes_on = 1'b0;
         clear_line();
         expected_tokens.delete();
      end else begin
         // a register write lands after the byte taken at the same edge
         if (req_valid && req_ready)
            tokenize_byte(req_char_in);
         if (csr_write_enable) begin
            if (csr_index == CSR_COMMENTS_ENABLE)
               comments_on = csr_data;
            else
               quotes_on = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("kind, none expected", {6'd0, rsp_kind}, 8'h00);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", {6'd0, rsp_kind}, {6'd0, want.kind});
               if (rsp_char_out !== want.char_out)
                  report_mismatch("char_out", rsp_char_out, want.char_out);
               if (rsp_status !== want.status)
                  report_mismatch("status", {6'd0, rsp_status}, {6'd0, want.status});
               if (rsp_word_count !== want.word_count)
                  report_mismatch("word_count", rsp_word_count, want.word_count);
               if (rsp_last !== want.last)
                  report_mismatch("last", {7'd0, rsp_last}, {7'd0, want.last});
            end
            token_index++;
         end
      end
      pending = expected_tokens.size();
   end

endmodule

// ===== test/tb_quoted_word_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_quoted_word_tokenizer import qwt_pkg::*;;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 65;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_char_out;
   logic [1:0] rsp_status;
   logic [7:0] rsp_word_count;
   logic       rsp_last;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = 1'b0;
   logic       csr_data = 1'b0;

   int         mismatch_count;
   int         tokens_pending;
   int         cycles = 0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   logic [7:0] line_bytes[$];

   quoted_word_tokenizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_char_out     (rsp_char_out),
      .rsp_status       (rsp_status),
      .rsp_word_count   (rsp_word_count),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   qwt_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_char_out     (rsp_char_out),
      .rsp_status       (rsp_status),
      .rsp_word_count   (rsp_word_count),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .errors           (mismatch_count),
      .pending          (tokens_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic logic [7:0] text_byte();
      if ($urandom_range(1))
         return 8'($urandom_range(8'h21, 8'h7E));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] mark_byte();
      case ($urandom_range(8))
         0: return CHAR_HASH;
         1: return CHAR_DQUOTE;
         2: return CHAR_SQUOTE;
         3: return CHAR_BACKSLASH;
         4: return CHAR_LOWER_N;
         5: return CHAR_TAB;
         6: return CHAR_CR;
         7: return CHAR_LF;
         default: return CHAR_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] gap_byte();
      case ($urandom_range(5))
         0: return CHAR_TAB;
         1: return CHAR_CR;
         2: return CHAR_LF;
         default: return CHAR_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] escape_byte();
      if ($urandom_range(9) == 0)
         return text_byte();
      case ($urandom_range(3))
         0: return CHAR_BACKSLASH;
         1: return CHAR_DQUOTE;
         2: return CHAR_SQUOTE;
         default: return CHAR_LOWER_N;
      endcase
   endfunction

   task automatic build_line();
      int shape;
      int tokens;
      int n;
      int k;
      int t;
      logic done;
      logic [7:0] closer;
      logic [7:0] b;
      line_bytes.delete();
      shape = $urandom_range(9);
      if (shape >= 8) begin
         // noise
         n = $urandom_range(12);
         for (k = 0; k < n; k++)
            line_bytes.push_back($urandom_range(1) ? mark_byte() : 8'($urandom_range(1, 255)));
      end else begin
         tokens = $urandom_range(5);
         done = 1'b0;
         for (t = 0; t < tokens && !done; t++) begin
            if ($urandom_range(2) == 0)
               line_bytes.push_back(gap_byte());
            case ($urandom_range(6))
               0, 1, 2: begin
                  n = $urandom_range(1, 6);
                  for (k = 0; k < n; k++)
                     line_bytes.push_back($urandom_range(4) == 0 ? mark_byte() : text_byte());
               end
               3, 4, 5: begin
                  closer = $urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE;
                  line_bytes.push_back(closer);
                  n = $urandom_range(5);
                  for (k = 0; k < n; k++) begin
                     if ($urandom_range(3) == 0) begin
                        line_bytes.push_back(CHAR_BACKSLASH);
                        line_bytes.push_back(escape_byte());
                     end else begin
                        b = text_byte();
                        if (b == closer || b == CHAR_BACKSLASH)
                           b = CHAR_LOWER_N;
                        line_bytes.push_back(b);
                     end
                  end
                  line_bytes.push_back(closer);
               end
               default: begin
                  // comment runs to the end of the line
                  line_bytes.push_back(CHAR_HASH);
                  n = $urandom_range(4);
                  for (k = 0; k < n; k++)
                     line_bytes.push_back($urandom_range(1) ? mark_byte() : text_byte());
                  done = 1'b1;
               end
            endcase
            if ($urandom_range(4) != 0)
               for (k = $urandom_range(1, 2); k > 0; k--)
                  line_bytes.push_back(gap_byte());
         end
         if (shape == 7) begin
            // quote left open, maybe with a bad or dangling escape
            line_bytes.push_back($urandom_range(1) ? CHAR_SQUOTE : CHAR_DQUOTE);
            n = $urandom_range(3);
            for (k = 0; k < n; k++)
               line_bytes.push_back(text_byte());
            case ($urandom_range(2))
               0: line_bytes.push_back(CHAR_BACKSLASH);
               1: begin
                  line_bytes.push_back(CHAR_BACKSLASH);
                  line_bytes.push_back(8'h71);
               end
               default: begin
               end
            endcase
         end
      end
      line_bytes.push_back(CHAR_NUL);
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_line();
      foreach (line_bytes[k])
         send_byte(line_bytes[k]);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tokens_pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_mode(input logic comments, input logic quotes);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_COMMENTS_ENABLE;
      csr_data <= comments;
      @(negedge clock);
      csr_index <= CSR_QUOTES_ENABLE;
      csr_data <= quotes;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input int quota);
      int sent;
      sent = 0;
      while (sent < quota) begin
         build_line();
         send_line();
         sent += line_bytes.size();
      end
   endtask

   initial begin
      int k;
      int pace;
      int mode;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // quote and hash are plain bytes with both features off
      line_bytes = '{CHAR_HASH, CHAR_SQUOTE, 8'h01, CHAR_NUL};
      send_line();
      wait_idle();
      set_mode(1'b1, 1'b1);
      line_bytes = '{CHAR_SQUOTE, CHAR_BACKSLASH, CHAR_LOWER_N, CHAR_SQUOTE,
                     CHAR_HASH, 8'h71, CHAR_NUL};
      send_line();
      line_bytes = '{CHAR_DQUOTE, CHAR_DQUOTE, 8'hFF, CHAR_HASH, CHAR_DQUOTE, CHAR_NUL};
      send_line();
      line_bytes = '{CHAR_DQUOTE, CHAR_BACKSLASH, 8'h71, CHAR_DQUOTE, CHAR_NUL};
      send_line();
      line_bytes = '{CHAR_SQUOTE, CHAR_BACKSLASH, CHAR_NUL};
      send_line();
      wait_idle();

      for (pace = 0; pace < 4; pace++) begin
         sender_idle_pct = (pace == 1) ? 63 : (pace == 3) ? 31 : 0;
         receiver_stall_pct = (pace == 2) ? 63 : (pace == 3) ? 31 : 0;
         for (mode = 0; mode < 4; mode++) begin
            set_mode(mode[0], mode[1]);
            if (pace == 0 && mode == 0) begin
               // enough words to saturate the count
               line_bytes.delete();
               for (k = 0; k < 260; k++) begin
                  line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                  line_bytes.push_back(gap_byte());
               end
               line_bytes.push_back(CHAR_NUL);
               send_line();
            end
            run_phase(PHASE_BYTES);
            wait_idle();
         end
      end

      if (mismatch_count == 0 && tokens_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
